/* src/qesc_pkg.sv */
// Types and constants shared by the quadrature encoder counter and its checker.
package qesc_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_MAX_COUNT = 8'd0;
  localparam logic [7:0] REG_MIN_COUNT = 8'd1;

  // Reset values of the limits and of the position count.
  localparam logic signed [15:0] MAX_COUNT_RESET = 16'sd100;
  localparam logic signed [15:0] MIN_COUNT_RESET = -16'sd100;
  localparam int POS_RESET = 50;

  // Line pattern as {dt, clk}.
  localparam logic [1:0] PAT_00 = 2'b00;
  localparam logic [1:0] PAT_01 = 2'b01;
  localparam logic [1:0] PAT_10 = 2'b10;
  localparam logic [1:0] PAT_11 = 2'b11;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_UP   = 2'd1,
    EV_DOWN = 2'd2
  } step_e;

  typedef enum logic [3:0] {
    SEQ_START = 4'd0,
    SEQ_HI    = 4'd1,
    SEQ_LO    = 4'd2,
    SEQ_CW1   = 4'd3,
    SEQ_CW2   = 4'd4,
    SEQ_CW3   = 4'd5,
    SEQ_CCW1  = 4'd6,
    SEQ_CCW2  = 4'd7,
    SEQ_CCW3  = 4'd8,
    SEQ_CW4   = 4'd9,
    SEQ_CW5   = 4'd10,
    SEQ_CW6   = 4'd11,
    SEQ_CCW4  = 4'd12,
    SEQ_CCW5  = 4'd13,
    SEQ_CCW6  = 4'd14
  } seq_state_e;

  typedef struct packed {
    logic clk_level;
    logic dt_level;
  } enc_in_t;

  typedef struct packed {
    logic signed [15:0] position;
    logic [1:0]         step_event;
    logic [3:0]         phase_state;
  } enc_out_t;

endpackage

/* src/quadrature_encoder_saturating_counter.sv */
// Quadrature encoder decoder with a saturating signed position counter.
//
// Usage: each input item is one sample of the encoder lines, clock (A) and
// data (B), offered on in_valid_i / in_ready_o. Every accepted item yields
// exactly one result item on out_valid_o / out_ready_i carrying the position
// after this sample, a step event (none, up or down) and the sequence state.
// The limits max_count (index 0) and min_count (index 1) are written through
// the configuration channel, which is always ready; writes to other indexes
// are ignored. Limits should only be changed while the block is idle.
// The result is shown in the cycle after acceptance, and the throughput is
// one item per cycle while the receiver keeps up: the state update and the
// saturating increment are a single pass of logic into the result register.
// When the receiver stalls, the result register holds its item and the input
// is refused until that item is taken; when it is taken, a new item can be
// accepted in the same cycle, so there is no bubble.
// Reset puts the sequence machine in its unsynchronised start state, the
// position at 50 and the limits at 100 and -100, and empties the result
// register.
module quadrature_encoder_saturating_counter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qesc_pkg::enc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qesc_pkg::enc_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import qesc_pkg::*;

  // Working width wide enough for the count, the 16-bit limits and a carry.
  localparam int W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;
  localparam logic signed [W-1:0] CntMax = W'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [W-1:0] CntMin = -CntMax - W'(1);

  seq_state_e state_q, state_d;
  step_e      step_ev;
  logic signed [COUNT_WIDTH-1:0] count_q, count_d;
  logic signed [15:0] max_q, min_q;
  logic       out_valid_q;
  enc_out_t   out_q;
  logic [1:0] pattern;
  logic       accept;

  logic signed [W-1:0] count_ext, max_ext, min_ext, sum_up, sum_dn, sat_val, res_ext;

  assign pattern     = {in_data_i.dt_level, in_data_i.clk_level};
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Next state of the sequence machine. A pattern that the current state does
  // not expect leaves it where it is, which also covers an unchanged sample.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_START: begin
        if (pattern == PAT_00) state_d = SEQ_LO;
        else if (pattern == PAT_11) state_d = SEQ_HI;
      end
      SEQ_HI: begin
        if (pattern == PAT_10) state_d = SEQ_CW1;
        else if (pattern == PAT_01) state_d = SEQ_CCW1;
      end
      SEQ_LO: begin
        if (pattern == PAT_01) state_d = SEQ_CW4;
        else if (pattern == PAT_10) state_d = SEQ_CCW4;
      end
      SEQ_CW1:  if (pattern == PAT_00) state_d = SEQ_CW2;
      SEQ_CW2:  if (pattern == PAT_01) state_d = SEQ_CW3;
      SEQ_CW3:  if (pattern == PAT_11) state_d = SEQ_HI;
      SEQ_CCW1: if (pattern == PAT_00) state_d = SEQ_CCW2;
      SEQ_CCW2: if (pattern == PAT_10) state_d = SEQ_CCW3;
      SEQ_CCW3: if (pattern == PAT_11) state_d = SEQ_HI;
      SEQ_CW4:  if (pattern == PAT_11) state_d = SEQ_CW5;
      SEQ_CW5:  if (pattern == PAT_10) state_d = SEQ_CW6;
      SEQ_CW6:  if (pattern == PAT_00) state_d = SEQ_LO;
      SEQ_CCW4: if (pattern == PAT_11) state_d = SEQ_CCW5;
      SEQ_CCW5: if (pattern == PAT_01) state_d = SEQ_CCW6;
      SEQ_CCW6: if (pattern == PAT_00) state_d = SEQ_LO;
      default:  state_d = state_q; // the unused code simply holds
    endcase
  end

  // Step event: counted at each half cycle once the direction is confirmed.
  always_comb begin
    step_ev = EV_NONE;
    unique case (state_q)
      SEQ_CW1, SEQ_CW6:   if (pattern == PAT_00) step_ev = EV_UP;
      SEQ_CW3, SEQ_CW4:   if (pattern == PAT_11) step_ev = EV_UP;
      SEQ_CCW1, SEQ_CCW6: if (pattern == PAT_00) step_ev = EV_DOWN;
      SEQ_CCW3, SEQ_CCW4: if (pattern == PAT_11) step_ev = EV_DOWN;
      default:            step_ev = EV_NONE;
    endcase
  end

  // Saturating count: first against the configured limit, then against the
  // range of the counter itself. A count past a limit snaps to it on a step further past it.
  always_comb begin
    count_ext = W'(count_q);
    max_ext   = W'(max_q);
    min_ext   = W'(min_q);
    sum_up    = count_ext + W'(1);
    sum_dn    = count_ext - W'(1);
    sat_val   = count_ext;
    unique case (step_ev)
      EV_UP:   sat_val = (sum_up > max_ext) ? max_ext : sum_up;
      EV_DOWN: sat_val = (sum_dn < min_ext) ? min_ext : sum_dn;
      default: sat_val = count_ext;
    endcase
    if (sat_val > CntMax)      res_ext = CntMax;
    else if (sat_val < CntMin) res_ext = CntMin;
    else                       res_ext = sat_val;
    count_d = res_ext[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_START;
      count_q     <= COUNT_WIDTH'(POS_RESET);
      max_q       <= MAX_COUNT_RESET;
      min_q       <= MIN_COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_MAX_COUNT) max_q <= cfg_data_i;
        else if (cfg_index_i == REG_MIN_COUNT) min_q <= cfg_data_i;
      end
      if (accept) begin
        state_q <= state_d;
        count_q <= count_d;
      end
      if (accept) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Result register; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.position    <= res_ext[15:0];
      out_q.step_event  <= step_ev;
      out_q.phase_state <= state_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/qesc_checker.sv */
// Port-level checker for the quadrature encoder counter, with its bind.
module qesc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input qesc_pkg::enc_out_t out_data_o
);
  import qesc_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // An empty result register must never refuse input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with an empty result register");

  // An up count ends a clockwise half cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.step_event == EV_UP |->
      out_data_o.phase_state == SEQ_CW2 || out_data_o.phase_state == SEQ_HI ||
      out_data_o.phase_state == SEQ_CW5 || out_data_o.phase_state == SEQ_LO)
    else $error("up count in an unexpected state");

  // A down count ends an anticlockwise half cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.step_event == EV_DOWN |->
      out_data_o.phase_state == SEQ_CCW2 || out_data_o.phase_state == SEQ_HI ||
      out_data_o.phase_state == SEQ_CCW5 || out_data_o.phase_state == SEQ_LO)
    else $error("down count in an unexpected state");

endmodule

bind quadrature_encoder_saturating_counter qesc_checker u_qesc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
